@@ design/tlvx_pkg.sv @@
// Shared types, parse phase codes and the per-byte parse step function.
package tlvx_pkg;

   localparam logic [3:0] PH_FIXED    = 4'd0;
   localparam logic [3:0] PH_PERHOP   = 4'd1;
   localparam logic [3:0] PH_MSG      = 4'd2;
   localparam logic [3:0] PH_INTEREST = 4'd3;
   localparam logic [3:0] PH_OBJECT   = 4'd4;
   localparam logic [3:0] PH_VALALG   = 4'd5;
   localparam logic [3:0] PH_VALTYPE  = 4'd6;
   localparam logic [3:0] PH_SIGPARAM = 4'd7;
   localparam logic [3:0] PH_DONE     = 4'd8;
   localparam logic [3:0] PH_REJECT   = 4'd9;
   localparam logic [3:0] PH_VERBAD   = 4'd10;

   localparam logic [1:0] ST_PARSED  = 2'd0;
   localparam logic [1:0] ST_REJECT  = 2'd1;
   localparam logic [1:0] ST_VERSION = 2'd2;

   localparam logic [7:0] KIND_INTEREST = 8'h00;
   localparam logic [7:0] KIND_CONTROL  = 8'hA4;

   localparam int unsigned FLG_REG   = 0;
   localparam int unsigned FLG_ADD   = 1;
   localparam int unsigned FLG_DEL   = 2;
   localparam int unsigned FLG_DEREG = 3;
   localparam int unsigned FLG_PAY   = 4;

   localparam logic [4:0] FID_NAME        = 5'd0;
   localparam logic [4:0] FID_KEYID       = 5'd1;
   localparam logic [4:0] FID_OBJHASH     = 5'd2;
   localparam logic [4:0] FID_HOPLIMIT    = 5'd3;
   localparam logic [4:0] FID_LIFETIME    = 5'd4;
   localparam logic [4:0] FID_CACHETIME   = 5'd5;
   localparam logic [4:0] FID_EXPIRY      = 5'd6;
   localparam logic [4:0] FID_CPI         = 5'd7;
   localparam logic [4:0] FID_FRAGMENT    = 5'd8;
   localparam logic [4:0] FID_CERT        = 5'd9;
   localparam logic [4:0] FID_PUBKEY      = 5'd10;
   localparam logic [4:0] FID_PATHLABEL   = 5'd11;
   localparam logic [4:0] FID_PAYLOAD     = 5'd12;
   localparam logic [4:0] FID_GETNAME     = 5'd13;
   localparam logic [4:0] FID_PAYGETNAME  = 5'd14;
   localparam logic [4:0] FID_KEYNAME     = 5'd15;
   localparam logic [4:0] FID_REG         = 5'd16;
   localparam logic [4:0] FID_ADD         = 5'd17;
   localparam logic [4:0] FID_DEL         = 5'd18;
   localparam logic [4:0] FID_DEREG       = 5'd19;
   localparam logic [4:0] FID_REG_NAME    = 5'd20;
   localparam logic [4:0] FID_ADD_NAME    = 5'd21;
   localparam logic [4:0] FID_DEL_NAME    = 5'd22;
   localparam logic [4:0] FID_DEREG_NAME  = 5'd23;

   localparam logic [15:0] T_CPI      = 16'hBEEF;
   localparam logic [15:0] T_PAY_A    = 16'h0111;
   localparam logic [15:0] T_OBJ_PAY  = 16'h0112;
   localparam logic [15:0] T_PAY_B    = 16'h0113;
   localparam logic [15:0] T_REG      = 16'h0114;
   localparam logic [15:0] T_ADD      = 16'h0117;
   localparam logic [15:0] T_DEL      = 16'h0120;
   localparam logic [15:0] T_DEREG    = 16'h0123;
   localparam logic [15:0] T_KEYID    = 16'h0009;
   localparam logic [15:0] T_PUBKEY   = 16'h000B;
   localparam logic [15:0] T_CERT     = 16'h000C;

   typedef struct packed {
      logic        kind;
      logic [4:0]  id;
      logic [15:0] off;
      logic [15:0] len;
      logic [1:0]  st;
   } rec_type;

   typedef struct packed {
      logic [3:0]  phase;
      logic [7:0]  kind;
      logic [15:0] pend;
      logic [7:0]  hend;
      logic [16:0] se0;
      logic [16:0] se1;
      logic [16:0] se2;
      logic [16:0] se3;
      logic [2:0]  fcnt;
      logic [4:0]  flags;
      logic        hvalid;
   } pst_type;

   typedef struct packed {
      pst_type     s;
      logic        again;
      logic [1:0]  n;
      rec_type     r0;
      rec_type     r1;
   } adv_type;

   typedef struct packed {
      logic [1:0]  n;
      rec_type     r0;
      rec_type     r1;
      rec_type     r2;
   } batch_type;

   function automatic rec_type mk_field(input logic [4:0] id, input logic [17:0] off,
                                        input logic [15:0] len);
      rec_type r;
      r.kind = 1'b0;
      r.id   = id;
      r.off  = off[15:0];
      r.len  = len;
      r.st   = ST_PARSED;
      return r;
   endfunction

   // One pass of the element walk for the byte at position p.
   function automatic adv_type advance(input pst_type s, input logic [15:0] p,
                                       input logic [31:0] sh);
      adv_type     o;
      logic [17:0] cur;
      logic [17:0] val;
      logic [17:0] endv;
      logic [17:0] p18;
      logic [17:0] pe18;
      logic [17:0] he18;
      logic [17:0] e0;
      logic [17:0] nxt;
      logic [15:0] typ;
      logic [15:0] len;
      logic        done;
      logic        hit;
      logic        descend;
      cur  = {1'b0, s.se1};
      typ  = sh[31:16];
      len  = sh[15:0];
      val  = cur + 18'd4;
      endv = val + {2'b00, len};
      p18  = {2'b00, p};
      pe18 = {2'b00, s.pend};
      he18 = {10'd0, s.hend};
      e0   = {1'b0, s.se0};
      done = (p18 == cur + 18'd3);
      nxt  = endv;
      hit  = 1'b1;
      descend = 1'b1;
      o.s = s;
      o.again = 1'b0;
      o.n = 2'd0;
      o.r0 = '0;
      o.r1 = '0;
      case (s.phase)
         PH_PERHOP: begin
            if (p18 >= he18) begin
               o.s.phase = PH_MSG;
               o.s.se1 = {9'd0, s.hend};
               o.again = 1'b1;
            end else if (done) begin
               if (val < he18 && endv <= he18) begin
                  if (typ == 16'd1) begin
                     o.r0 = mk_field(FID_LIFETIME, val, len); o.n = 2'd1;
                  end else if (typ == 16'd2) begin
                     o.r0 = mk_field(FID_CACHETIME, val, len); o.n = 2'd1;
                  end else if (typ == 16'd3) begin
                     o.r0 = mk_field(FID_PATHLABEL, val, len); o.n = 2'd1;
                  end
               end
               o.s.se1 = endv[16:0];
            end
         end
         PH_MSG: begin
            if (p18 >= pe18) begin
               o.s.phase = PH_DONE;
            end else if (done) begin
               if (val < pe18 && endv <= pe18) begin
                  o.s.se2 = endv[16:0];
                  if (typ == 16'd1 || typ == 16'd2 || typ == 16'd6) begin
                     o.s.phase = (typ == 16'd1) ? PH_INTEREST : PH_OBJECT;
                     o.s.se0 = endv[16:0];
                     o.s.se1 = val[16:0];
                     o.s.fcnt = 3'd0;
                  end else begin
                     if (typ == T_CPI) begin
                        o.r0 = mk_field(FID_CPI, val, len); o.n = 2'd1;
                     end else if (typ == 16'd5) begin
                        o.r0 = mk_field(FID_FRAGMENT, val, len); o.n = 2'd1;
                     end
                     o.s.phase = PH_VALALG;
                     o.s.se1 = endv[16:0];
                  end
               end else begin
                  o.s.phase = PH_DONE;
               end
            end
         end
         PH_INTEREST, PH_OBJECT: begin
            if (p18 >= e0) begin
               o.s.phase = PH_VALALG;
               o.s.se1 = s.se0;
               o.again = 1'b1;
            end else if (s.fcnt < 3'd4 && done) begin
               if (endv <= e0) begin
                  if (s.phase == PH_INTEREST) begin
                     o.n = 2'd1;
                     case (typ)
                        16'h0000: begin
                           descend = 1'b0;
                           if (s.flags[FLG_REG])
                              o.r0 = mk_field(FID_REG_NAME, val, len);
                           else if (s.flags[FLG_ADD])
                              o.r0 = mk_field(FID_ADD_NAME, val, len);
                           else if (s.flags[FLG_DEL])
                              o.r0 = mk_field(FID_DEL_NAME, val, len);
                           else if (s.flags[FLG_DEREG])
                              o.r0 = mk_field(FID_DEREG_NAME, val, len);
                           else if (s.flags[FLG_PAY]) begin
                              o.r0 = mk_field(FID_GETNAME, val, len);
                              o.r1 = mk_field(FID_KEYNAME, val, len);
                              o.n = 2'd2;
                           end else
                              o.r0 = mk_field(FID_NAME, val, len);
                        end
                        16'h0002: begin
                           descend = 1'b0; o.r0 = mk_field(FID_KEYID, val, len);
                        end
                        16'h0003: begin
                           descend = 1'b0; o.r0 = mk_field(FID_OBJHASH, val, len);
                        end
                        T_REG: begin
                           o.r0 = mk_field(FID_REG, val, len);
                           o.s.flags[FLG_REG] = (len != 16'd0);
                        end
                        T_ADD: begin
                           o.r0 = mk_field(FID_ADD, val, len);
                           o.s.flags[FLG_ADD] = (len != 16'd0);
                        end
                        T_DEL: begin
                           o.r0 = mk_field(FID_DEL, val, len);
                           o.s.flags[FLG_DEL] = (len != 16'd0);
                        end
                        T_DEREG: begin
                           o.r0 = mk_field(FID_DEREG, val, len);
                           o.s.flags[FLG_DEREG] = (len != 16'd0);
                        end
                        T_PAY_A, T_PAY_B: begin
                           o.r0 = mk_field(FID_PAYLOAD, val, len);
                           o.s.flags[FLG_PAY] = (len != 16'd0);
                        end
                        default: begin
                           hit = 1'b0; o.n = 2'd0;
                        end
                     endcase
                     if (hit && descend) nxt = val;
                  end else begin
                     o.n = 2'd1;
                     case (typ)
                        16'h0000: begin
                           if (endv < e0 || s.fcnt == 3'd0)
                              o.r0 = mk_field(FID_NAME, val, len);
                           else
                              o.r0 = mk_field(FID_PAYGETNAME, val, len);
                        end
                        16'h0006: o.r0 = mk_field(FID_EXPIRY, val, len);
                        T_OBJ_PAY: begin
                           o.r0 = mk_field(FID_PAYLOAD, val, len);
                           o.s.flags[FLG_PAY] = (len != 16'd0);
                           nxt = val;
                        end
                        default: begin
                           hit = 1'b0; o.n = 2'd0;
                        end
                     endcase
                  end
                  if (hit) o.s.fcnt = s.fcnt + 3'd1;
               end
               o.s.se1 = nxt[16:0];
            end
         end
         PH_VALALG: begin
            if (p18 >= pe18) begin
               o.s.phase = PH_DONE;
            end else if (done) begin
               if (val < pe18 && endv <= pe18 && typ == 16'd3) begin
                  o.s.phase = PH_VALTYPE;
                  o.s.se3 = endv[16:0];
                  o.s.se0 = endv[16:0];
                  o.s.se1 = val[16:0];
               end else begin
                  o.s.phase = PH_DONE;
               end
            end
         end
         PH_VALTYPE: begin
            if (p18 >= e0) begin
               o.s.phase = PH_DONE;
            end else if (done) begin
               if (val < e0 && endv <= e0 && typ >= 16'd6 && typ <= 16'd8) begin
                  o.s.phase = PH_SIGPARAM;
                  o.s.se0 = endv[16:0];
                  o.s.se1 = val[16:0];
               end else begin
                  o.s.phase = PH_DONE;
               end
            end
         end
         PH_SIGPARAM: begin
            if (p18 >= e0) begin
               o.s.phase = PH_DONE;
            end else if (done) begin
               if (val < e0 && endv <= e0) begin
                  if (typ == T_KEYID) begin
                     o.r0 = mk_field(FID_KEYID, val, len); o.n = 2'd1;
                  end else if (typ == T_CERT) begin
                     o.r0 = mk_field(FID_CERT, val, len); o.n = 2'd1;
                  end else if (typ == T_PUBKEY) begin
                     o.r0 = mk_field(FID_PUBKEY, val, len); o.n = 2'd1;
                  end
               end
               o.s.se1 = endv[16:0];
            end
         end
         default: begin
            o.s = s;
         end
      endcase
      return o;
   endfunction

endpackage

@@ design/tlvx_core.sv @@
// Parse state registers and the per-byte parse step of up to two walk passes.
module tlvx_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output tlvx_pkg::batch_type batch
);

   tlvx_pkg::pst_type st_ff, st_in;
   logic [31:0]       sh_ff, sh_in;
   logic [15:0]       pos_ff, pos_in;

   tlvx_pkg::pst_type  ps;
   tlvx_pkg::adv_type  a1, a2, af;
   tlvx_pkg::rec_type  fx_rec;
   tlvx_pkg::rec_type  stat_rec;
   logic               fx_n;
   logic [31:0]        sh_new;
   logic [1:0]         stat_code;
   logic [1:0]         nfield;
   tlvx_pkg::rec_type  f0, f1;

   always_comb begin
      sh_new = {sh_ff[23:0], data_byte};
      ps     = st_ff;
      fx_rec = '0;
      fx_n   = 1'b0;
      a1     = tlvx_pkg::advance(st_ff, pos_ff, sh_new);
      a2     = tlvx_pkg::advance(a1.s, pos_ff, sh_new);
      af     = a1.again ? a2 : a1;
      if (st_ff.phase == tlvx_pkg::PH_FIXED) begin
         case (pos_ff)
            16'd0: ps.hvalid = (data_byte == 8'd1);
            16'd1: ps.kind = data_byte;
            16'd2: ps.pend = {data_byte, 8'd0};
            16'd3: ps.pend = {st_ff.pend[15:8], data_byte};
            16'd7: begin
               ps.hend = data_byte;
               if (!st_ff.hvalid) begin
                  ps.phase = tlvx_pkg::PH_VERBAD;
               end else if ((st_ff.kind == tlvx_pkg::KIND_INTEREST || st_ff.kind == 8'd1 ||
                             st_ff.kind == 8'd2 || st_ff.kind == 8'd4 ||
                             st_ff.kind == tlvx_pkg::KIND_CONTROL) &&
                            data_byte >= 8'd8 && st_ff.pend >= {8'd0, data_byte}) begin
                  if (st_ff.kind == tlvx_pkg::KIND_INTEREST) begin
                     fx_rec = tlvx_pkg::mk_field(tlvx_pkg::FID_HOPLIMIT, 18'd4, 16'd1);
                     fx_n   = 1'b1;
                  end
                  ps.phase = tlvx_pkg::PH_PERHOP;
                  ps.se0   = {9'd0, data_byte};
                  ps.se1   = 17'd8;
               end else begin
                  ps.phase = tlvx_pkg::PH_REJECT;
               end
            end
            default: ps = st_ff;
         endcase
         nfield = {1'b0, fx_n};
         f0 = fx_rec;
         f1 = '0;
      end else begin
         ps     = af.s;
         nfield = af.n;
         f0     = af.r0;
         f1     = af.r1;
      end

      if (ps.phase == tlvx_pkg::PH_VERBAD)      stat_code = tlvx_pkg::ST_VERSION;
      else if (ps.phase == tlvx_pkg::PH_REJECT) stat_code = tlvx_pkg::ST_REJECT;
      else if (ps.phase == tlvx_pkg::PH_FIXED)
         stat_code = ps.hvalid ? tlvx_pkg::ST_REJECT : tlvx_pkg::ST_VERSION;
      else                                      stat_code = tlvx_pkg::ST_PARSED;
      stat_rec      = '0;
      stat_rec.kind = 1'b1;
      stat_rec.st   = stat_code;

      batch.r0 = f0;
      batch.r1 = f1;
      batch.r2 = stat_rec;
      batch.n  = nfield;
      if (last_byte) begin
         batch.n = nfield + 2'd1;
         case (nfield)
            2'd0:    batch.r0 = stat_rec;
            2'd1:    batch.r1 = stat_rec;
            default: batch.r2 = stat_rec;
         endcase
      end

      // clear the whole packet context after the status beat
      if (last_byte) begin
         st_in  = '0;
         sh_in  = '0;
         pos_in = '0;
      end else begin
         st_in  = ps;
         sh_in  = sh_new;
         pos_in = (pos_ff != 16'hFFFF) ? pos_ff + 16'd1 : pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= '0;
         sh_ff  <= '0;
         pos_ff <= '0;
      end else if (accept) begin
         st_ff  <= st_in;
         sh_ff  <= sh_in;
         pos_ff <= pos_in;
      end
   end

endmodule

@@ design/tlv_packet_field_extractor_top.sv @@
// Top level of the TLV packet field extractor: parse step plus record queue.
//
// Usage: feed packet bytes in wire order on the req_ channel, one beat per
// byte, with req_last_byte high on the final byte of the buffer. Each byte is
// parsed in the cycle it is accepted; the records it causes (zero to three:
// field extents, then an end-of-packet status on the last byte) are loaded
// into a three-entry result queue and leave one per beat on the rsp_ channel,
// rsp_last_record marking the final record of that byte.
// A byte's records are registered into the queue as it is accepted, and the first shows on rsp_ in the next cycle.
// Throughput: one byte per cycle while each byte yields at most one record and
// the receiver takes every record; a byte yielding more records holds the input
// until the single output port has drained the queue to its last record.
// Reset (synchronous, active high) clears the parse context and empties the
// queue; the parser also restarts its context after every status record.
// When the receiver stalls, the queued records hold and req_ready stays low
// until the final record of the current byte is leaving.
module tlv_packet_field_extractor_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_record_kind,
   output logic [4:0]  rsp_field_id,
   output logic [15:0] rsp_field_offset,
   output logic [15:0] rsp_field_length,
   output logic [1:0]  rsp_parse_status,
   output logic        rsp_last_record
);

   tlvx_pkg::batch_type batch;
   tlvx_pkg::rec_type   q0_ff, q1_ff, q2_ff;
   tlvx_pkg::rec_type   q0_in, q1_in, q2_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic                accept;
   logic                pop;

   // take a new byte when the queue is empty or its last record leaves now
   assign req_ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;

   tlvx_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .batch     (batch)
   );

   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      q2_in  = q2_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         // load the records of the new byte
         q0_in  = batch.r0;
         q1_in  = batch.r1;
         q2_in  = batch.r2;
         cnt_in = batch.n;
      end else if (pop) begin
         // advance the queue by one beat
         q0_in  = q1_ff;
         q1_in  = q2_ff;
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
      q2_ff <= q2_in;
   end

   assign rsp_record_kind  = q0_ff.kind;
   assign rsp_field_id     = q0_ff.id;
   assign rsp_field_offset = q0_ff.off;
   assign rsp_field_length = q0_ff.len;
   assign rsp_parse_status = q0_ff.st;
   assign rsp_last_record  = (cnt_ff == 2'd1);

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      accept |-> (cnt_ff == 2'd0 || pop))
      else $error("byte accepted over undelivered records");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> (cnt_ff == $past(batch.n)))
      else $error("queue count differs from records produced");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_kind) |-> rsp_last_record)
      else $error("status record is not the final record of its byte");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_kind) |->
         (rsp_field_id == 5'd0 && rsp_field_offset == 16'd0 && rsp_field_length == 16'd0))
      else $error("status record carries field data");

endmodule

@@ sim/tlv_record_checker.sv @@
// Record checker: predicts the records of every accepted byte and compares the rsp_ beats.
module tlv_record_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_record_kind,
   input  logic [4:0]  rsp_field_id,
   input  logic [15:0] rsp_field_offset,
   input  logic [15:0] rsp_field_length,
   input  logic [1:0]  rsp_parse_status,
   input  logic        rsp_last_record,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        kind;
      logic [4:0]  id;
      logic [15:0] off;
      logic [15:0] len;
      logic [1:0]  st;
      logic        last;
   } record_type;

   record_type pending_records[$];

   int unsigned byte_pos, pkt_kind, pkt_end, hdr_end, hdr_shift, found_cnt;
   int unsigned bounds[4];
   logic [3:0]  phase;
   logic [4:0]  flags;
   logic        ver_ok;

   assign pending_count = pending_records.size();

   function automatic void emit(logic kind, logic [4:0] id, int unsigned off,
                                int unsigned len, logic [1:0] st);
      record_type r;
      r.kind = kind; r.id = id; r.off = off[15:0]; r.len = len[15:0];
      r.st = st; r.last = 1'b0;
      pending_records.push_back(r);
   endfunction

   function automatic void field(logic [4:0] id, int unsigned off, int unsigned len);
      emit(1'b0, id, off, len, tlvx_pkg::ST_PARSED);
   endfunction

   function automatic void clear_context();
      byte_pos = 0; pkt_kind = 0; pkt_end = 0; hdr_end = 0; hdr_shift = 0;
      bounds[0] = 0; bounds[1] = 0; bounds[2] = 0; bounds[3] = 0;
      phase = tlvx_pkg::PH_FIXED; found_cnt = 0; flags = '0; ver_ok = 1'b0;
   endfunction

   function automatic void interest_item(int unsigned t, int unsigned v, int unsigned l,
                                         ref int unsigned nxt);
      bit descend;
      descend = 1;
      case (t)
         'h0000: begin
            if (flags[tlvx_pkg::FLG_REG]) field(tlvx_pkg::FID_REG_NAME, v, l);
            else if (flags[tlvx_pkg::FLG_ADD]) field(tlvx_pkg::FID_ADD_NAME, v, l);
            else if (flags[tlvx_pkg::FLG_DEL]) field(tlvx_pkg::FID_DEL_NAME, v, l);
            else if (flags[tlvx_pkg::FLG_DEREG]) field(tlvx_pkg::FID_DEREG_NAME, v, l);
            else if (flags[tlvx_pkg::FLG_PAY]) begin
               field(tlvx_pkg::FID_GETNAME, v, l); field(tlvx_pkg::FID_KEYNAME, v, l);
            end else field(tlvx_pkg::FID_NAME, v, l);
            descend = 0;
         end
         'h0002: begin field(tlvx_pkg::FID_KEYID, v, l); descend = 0; end
         'h0003: begin field(tlvx_pkg::FID_OBJHASH, v, l); descend = 0; end
         tlvx_pkg::T_REG: begin
            field(tlvx_pkg::FID_REG, v, l); flags[tlvx_pkg::FLG_REG] = (l != 0);
         end
         tlvx_pkg::T_ADD: begin
            field(tlvx_pkg::FID_ADD, v, l); flags[tlvx_pkg::FLG_ADD] = (l != 0);
         end
         tlvx_pkg::T_DEL: begin
            field(tlvx_pkg::FID_DEL, v, l); flags[tlvx_pkg::FLG_DEL] = (l != 0);
         end
         tlvx_pkg::T_DEREG: begin
            field(tlvx_pkg::FID_DEREG, v, l); flags[tlvx_pkg::FLG_DEREG] = (l != 0);
         end
         tlvx_pkg::T_PAY_A, tlvx_pkg::T_PAY_B: begin
            field(tlvx_pkg::FID_PAYLOAD, v, l); flags[tlvx_pkg::FLG_PAY] = (l != 0);
         end
         default: return;
      endcase
      found_cnt++;
      if (descend) nxt = v;
   endfunction

   function automatic void object_item(int unsigned t, int unsigned v, int unsigned l,
                                       int unsigned e, ref int unsigned nxt);
      case (t)
         'h0000: begin
            if (e < bounds[0] || found_cnt == 0) field(tlvx_pkg::FID_NAME, v, l);
            else field(tlvx_pkg::FID_PAYGETNAME, v, l);
         end
         'h0006: field(tlvx_pkg::FID_EXPIRY, v, l);
         tlvx_pkg::T_OBJ_PAY: begin
            field(tlvx_pkg::FID_PAYLOAD, v, l); flags[tlvx_pkg::FLG_PAY] = (l != 0);
            nxt = v;
         end
         default: return;
      endcase
      found_cnt++;
   endfunction

   // One walk pass; return 1 when the same byte must be walked again.
   function automatic bit walk(int unsigned p);
      int unsigned cur, t, l, v, e, nxt;
      bit done;
      cur = bounds[1]; t = hdr_shift >> 16; l = hdr_shift & 'hFFFF;
      v = cur + 4; e = v + l; done = (p == cur + 3);
      case (phase)
         tlvx_pkg::PH_PERHOP: begin
            if (p >= hdr_end) begin
               phase = tlvx_pkg::PH_MSG; bounds[1] = hdr_end; return 1;
            end
            if (done) begin
               if (v < hdr_end && e <= hdr_end) begin
                  if (t == 1) field(tlvx_pkg::FID_LIFETIME, v, l);
                  else if (t == 2) field(tlvx_pkg::FID_CACHETIME, v, l);
                  else if (t == 3) field(tlvx_pkg::FID_PATHLABEL, v, l);
               end
               bounds[1] = e;
            end
         end
         tlvx_pkg::PH_MSG: begin
            if (p >= pkt_end) phase = tlvx_pkg::PH_DONE;
            else if (done) begin
               if (v < pkt_end && e <= pkt_end) begin
                  bounds[2] = e;
                  if (t == 1 || t == 2 || t == 6) begin
                     phase = (t == 1) ? tlvx_pkg::PH_INTEREST : tlvx_pkg::PH_OBJECT;
                     bounds[0] = e; bounds[1] = v; found_cnt = 0;
                  end else begin
                     if (t == tlvx_pkg::T_CPI) field(tlvx_pkg::FID_CPI, v, l);
                     else if (t == 5) field(tlvx_pkg::FID_FRAGMENT, v, l);
                     phase = tlvx_pkg::PH_VALALG; bounds[1] = e;
                  end
               end else phase = tlvx_pkg::PH_DONE;
            end
         end
         tlvx_pkg::PH_INTEREST, tlvx_pkg::PH_OBJECT: begin
            if (p >= bounds[0]) begin
               phase = tlvx_pkg::PH_VALALG; bounds[1] = bounds[0]; return 1;
            end
            if (found_cnt < 4 && done) begin
               nxt = e;
               if (e <= bounds[0]) begin
                  if (phase == tlvx_pkg::PH_INTEREST) interest_item(t, v, l, nxt);
                  else object_item(t, v, l, e, nxt);
               end
               bounds[1] = nxt;
            end
         end
         tlvx_pkg::PH_VALALG: begin
            if (p >= pkt_end) phase = tlvx_pkg::PH_DONE;
            else if (done) begin
               if (v < pkt_end && e <= pkt_end && t == 3) begin
                  phase = tlvx_pkg::PH_VALTYPE; bounds[3] = e; bounds[0] = e; bounds[1] = v;
               end else phase = tlvx_pkg::PH_DONE;
            end
         end
         tlvx_pkg::PH_VALTYPE: begin
            if (p >= bounds[0]) phase = tlvx_pkg::PH_DONE;
            else if (done) begin
               if (v < bounds[0] && e <= bounds[0] && t >= 6 && t <= 8) begin
                  phase = tlvx_pkg::PH_SIGPARAM; bounds[0] = e; bounds[1] = v;
               end else phase = tlvx_pkg::PH_DONE;
            end
         end
         tlvx_pkg::PH_SIGPARAM: begin
            if (p >= bounds[0]) phase = tlvx_pkg::PH_DONE;
            else if (done) begin
               if (v < bounds[0] && e <= bounds[0]) begin
                  if (t == tlvx_pkg::T_KEYID) field(tlvx_pkg::FID_KEYID, v, l);
                  else if (t == tlvx_pkg::T_CERT) field(tlvx_pkg::FID_CERT, v, l);
                  else if (t == tlvx_pkg::T_PUBKEY) field(tlvx_pkg::FID_PUBKEY, v, l);
               end
               bounds[1] = e;
            end
         end
         default: ;
      endcase
      return 0;
   endfunction

   function automatic void fixed_header(int unsigned p, int unsigned b);
      if (p == 0) ver_ok = (b == 1);
      else if (p == 1) pkt_kind = b;
      else if (p == 2) pkt_end = b << 8;
      else if (p == 3) pkt_end |= b;
      else if (p == 7) begin
         hdr_end = b;
         if (!ver_ok) phase = tlvx_pkg::PH_VERBAD;
         else if ((pkt_kind inside {0, 1, 2, 4, tlvx_pkg::KIND_CONTROL}) && hdr_end >= 8 &&
                  pkt_end >= hdr_end) begin
            if (pkt_kind == tlvx_pkg::KIND_INTEREST) field(tlvx_pkg::FID_HOPLIMIT, 4, 1);
            phase = tlvx_pkg::PH_PERHOP; bounds[0] = hdr_end; bounds[1] = 8;
         end else phase = tlvx_pkg::PH_REJECT;
      end
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic last);
      int n0, g;
      logic [1:0] st;
      n0 = pending_records.size();
      hdr_shift = (hdr_shift << 8) | b;
      if (phase == tlvx_pkg::PH_FIXED) fixed_header(byte_pos, b);
      else
         for (g = 0; g < 4; g++)
            if (!walk(byte_pos)) break;
      if (last) begin
         if (phase == tlvx_pkg::PH_VERBAD) st = tlvx_pkg::ST_VERSION;
         else if (phase == tlvx_pkg::PH_REJECT) st = tlvx_pkg::ST_REJECT;
         else if (phase == tlvx_pkg::PH_FIXED)
            st = ver_ok ? tlvx_pkg::ST_REJECT : tlvx_pkg::ST_VERSION;
         else st = tlvx_pkg::ST_PARSED;
         emit(1'b1, '0, 0, 0, st);
         clear_context();
      end else if (byte_pos < 'hFFFF) byte_pos++;
      if (pending_records.size() > n0)
         pending_records[pending_records.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      record_type x;
      if (reset) begin
         clear_context();
         pending_records.delete();
         fail_count = 0;
      end else begin
         // Compare first: a record never leaves in the cycle its byte is taken.
         if (rsp_valid && rsp_ready) begin
            if (pending_records.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected record kind=%0d id=%0d off=%0d len=%0d st=%0d",
                           rsp_record_kind, rsp_field_id, rsp_field_offset,
                           rsp_field_length, rsp_parse_status);
            end else begin
               x = pending_records.pop_front();
               if (x.kind !== rsp_record_kind || x.id !== rsp_field_id ||
                   x.off !== rsp_field_offset || x.len !== rsp_field_length ||
                   x.st !== rsp_parse_status || x.last !== rsp_last_record) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"record mismatch exp kind=%0d id=%0d off=%0d len=%0d st=%0d",
                               " last=%0d act kind=%0d id=%0d off=%0d len=%0d st=%0d",
                               " last=%0d"},
                              x.kind, x.id, x.off, x.len, x.st, x.last,
                              rsp_record_kind, rsp_field_id, rsp_field_offset,
                              rsp_field_length, rsp_parse_status, rsp_last_record);
               end
            end
         end
         if (req_valid && req_ready) parse_byte(req_data_byte, req_last_byte);
      end
   end

endmodule

@@ sim/tlv_packet_field_extractor_top_tb.sv @@
// Testbench top: builds packet byte streams, drives the block and gives the verdict.
module tlv_packet_field_extractor_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] bytes_type[$];

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_record_kind;
   logic [4:0]  rsp_field_id;
   logic [15:0] rsp_field_offset;
   logic [15:0] rsp_field_length;
   logic [1:0]  rsp_parse_status;
   logic        rsp_last_record;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   bit          calm;

   logic [7:0]  beat_data[$];
   logic        beat_last[$];

   tlv_packet_field_extractor_top u_dut (.*);

   tlv_record_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop: generous cap over the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 50000) begin
         $display("tlv_packet_field_extractor_top verification failed");
         $finish;
      end
   end

   // Receiver back-pressure: rsp_ready is low with about 29 percent chance outside the calm window.
   always @(negedge clock)
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);

   function automatic bytes_type rand_bytes(int n);
      bytes_type r;
      for (int i = 0; i < n; i++) r.push_back(8'($urandom_range(255)));
      return r;
   endfunction

   // Wrap a value as one type/length element; now and then lie about the length.
   function automatic bytes_type tlv(logic [15:0] t, bytes_type v);
      bytes_type r;
      logic [15:0] l;
      l = 16'(v.size());
      case ($urandom_range(15))
         0: l = 16'($urandom_range(32'(l) + 6));
         1: l = 16'hFFFF;
         default: ;
      endcase
      r = {t[15:8], t[7:0], l[15:8], l[7:0]};
      foreach (v[i]) r.push_back(v[i]);
      return r;
   endfunction

   function automatic bytes_type cat(bytes_type a, bytes_type b);
      foreach (b[i]) a.push_back(b[i]);
      return a;
   endfunction

   function automatic bytes_type name_tlv();
      return tlv(16'h0000, rand_bytes($urandom_range(3)));
   endfunction

   function automatic bytes_type interest_body();
      bytes_type r;
      logic [15:0] regs[4];
      regs = '{tlvx_pkg::T_REG, tlvx_pkg::T_ADD, tlvx_pkg::T_DEL, tlvx_pkg::T_DEREG};
      repeat ($urandom_range(6)) begin
         case ($urandom_range(9))
            0: r = cat(r, name_tlv());
            1: r = cat(r, tlv(16'h0002, rand_bytes($urandom_range(2))));
            2: r = cat(r, tlv(16'h0003, rand_bytes($urandom_range(2))));
            3, 4: r = cat(r, tlv(regs[$urandom_range(3)],
                                 $urandom_range(3) ? name_tlv() : rand_bytes(0)));
            5: r = cat(r, tlv(tlvx_pkg::T_PAY_A,
                              $urandom_range(3) ? name_tlv() : rand_bytes(0)));
            6: r = cat(r, tlv(tlvx_pkg::T_PAY_B, name_tlv()));
            7: r = cat(r, name_tlv());
            default: r = cat(r, tlv(16'($urandom_range(16'hFFFF)),
                                    rand_bytes($urandom_range(2))));
         endcase
      end
      return r;
   endfunction

   function automatic bytes_type object_body();
      bytes_type r;
      repeat ($urandom_range(6)) begin
         case ($urandom_range(4))
            0: r = cat(r, name_tlv());
            1: r = cat(r, tlv(16'h0006, rand_bytes($urandom_range(2))));
            2, 3: r = cat(r, tlv(tlvx_pkg::T_OBJ_PAY,
                                 $urandom_range(3) ? name_tlv() : rand_bytes(0)));
            default: r = cat(r, tlv(16'($urandom_range(16'hFFFF)), rand_bytes(1)));
         endcase
      end
      return r;
   endfunction

   function automatic bytes_type validation();
      bytes_type s;
      logic [15:0] kinds[4];
      kinds = '{tlvx_pkg::T_KEYID, tlvx_pkg::T_CERT, tlvx_pkg::T_PUBKEY, 16'h0001};
      repeat ($urandom_range(3))
         s = cat(s, tlv(kinds[$urandom_range(3)], rand_bytes($urandom_range(3))));
      s = tlv($urandom_range(7) ? 16'(6 + $urandom_range(2)) : 16'(5), s);
      return tlv($urandom_range(7) ? 16'h0003 : 16'h0004, s);
   endfunction

   // Queue one packet: fixed header, hop-by-hop block, message, validation.
   function automatic void add_packet(logic [7:0] ver, logic [7:0] kind, int n_hop,
                                      int msg_sel, bit with_val, int tail);
      bytes_type   ph, body, pkt;
      logic [15:0] plen;
      logic [7:0]  hlen;
      logic [15:0] htypes[4];
      int          nbytes;
      htypes = '{16'h0001, 16'h0002, 16'h0003, 16'h0007};
      repeat (n_hop)
         ph = cat(ph, tlv(htypes[$urandom_range(3)], rand_bytes($urandom_range(3))));
      case (msg_sel)
         0: body = tlv(16'h0001, interest_body());
         1: body = tlv(16'h0002, object_body());
         2: body = tlv(16'h0006, object_body());
         3: body = tlv(tlvx_pkg::T_CPI, rand_bytes($urandom_range(3)));
         4: body = tlv(16'h0005, rand_bytes($urandom_range(3)));
         default: body = tlv(16'($urandom_range(16'hFFFF)), rand_bytes(1));
      endcase
      if (with_val) body = cat(body, validation());
      hlen = 8'(8 + ph.size());
      plen = 16'(32'(hlen) + body.size());
      case ($urandom_range(19))
         0: plen = 16'($urandom_range(16'hFFFF));
         1: plen = 16'(32'(hlen) - 1);
         2: hlen = 8'($urandom_range(7));
         3: hlen = 8'(8 + $urandom_range(ph.size()));
         default: ;
      endcase
      pkt = {ver, kind, plen[15:8], plen[7:0]};
      pkt = cat(pkt, rand_bytes(3));
      pkt.push_back(hlen);
      pkt = cat(cat(pkt, ph), body);
      nbytes = pkt.size() + tail;
      if (tail < 0) nbytes = int'($urandom_range(pkt.size() - 1)) + 1;
      pkt = cat(pkt, rand_bytes(tail > 0 ? tail : 0));
      for (int i = 0; i < nbytes; i++) begin
         beat_data.push_back(pkt[i]);
         beat_last.push_back(i == nbytes - 1);
      end
   endfunction

   function automatic void add_raw(bytes_type b);
      foreach (b[i]) begin
         beat_data.push_back(b[i]);
         beat_last.push_back(i == b.size() - 1);
      end
   endfunction

   function automatic logic [7:0] pick_kind();
      logic [7:0] k[5];
      k = '{8'h00, 8'h01, 8'h02, 8'h04, tlvx_pkg::KIND_CONTROL};
      return $urandom_range(9) ? k[$urandom_range(4)] : 8'($urandom_range(255));
   endfunction

   initial begin
      int tail;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      calm = 1'b0;

      // Directed: version not one, bad type, short header length, buffers ending
      // inside the fixed header, an interest with hop limit and an object packet.
      add_raw({8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h08, 8'hFF});
      add_raw({8'h01, 8'h03, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h08});
      add_raw({8'h01, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h05});
      add_raw({8'h01, 8'hFF});
      add_raw({8'hFE});
      add_packet(8'h01, 8'h00, 1, 0, 1, 0);
      add_packet(8'h01, 8'h01, 0, 1, 1, 0);

      // Random: mostly well-formed packets, some truncated, padded or pure noise.
      while (beat_data.size() < 320) begin
         if ($urandom_range(9) == 0)
            add_raw(rand_bytes($urandom_range(12) + 1));
         else begin
            tail = 0;
            case ($urandom_range(7))
               0: tail = -1;
               1: tail = $urandom_range(4) + 1;
               default: ;
            endcase
            add_packet($urandom_range(9) ? 8'h01 : 8'($urandom_range(255)), pick_kind(),
                       $urandom_range(3), $urandom_range(7) ? $urandom_range(2)
                       : $urandom_range(5), $urandom_range(4) != 0, tail);
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < beat_data.size(); i++) begin
         // Calm window: no idling on either side for a long stretch of random beats.
         calm = (i >= 120 && i < 200);
         while (!calm && $urandom_range(99) < 29) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data_byte <= beat_data[i];
         req_last_byte <= beat_last[i];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // Drain: wait for every predicted record, then a short settle.
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("tlv_packet_field_extractor_top verification clean");
      else
         $display("tlv_packet_field_extractor_top verification failed");
      $finish;
   end

endmodule

@@ tlv_packet_field_extractor_top.f @@
design/tlvx_pkg.sv
design/tlvx_core.sv
design/tlv_packet_field_extractor_top.sv
sim/tlv_record_checker.sv
sim/tlv_packet_field_extractor_top_tb.sv
